@@ rtl/oerf_pkg.sv @@
// shared constants, types and helpers of the overwriting entry ring
package oerf_pkg;

  // ring geometry and field widths
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int OFS_W    = 20;
  localparam int ENTRY_W  = HANDLE_W + SIZE_W;
  // running size total over the whole ring, and the width it is compared at
  localparam int ACC_W    = SIZE_W + IDX_W;
  localparam int CMP_W    = (ACC_W + 1 > OFS_W) ? ACC_W + 1 : OFS_W;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic add_wr;
    logic find_step;
    logic sel_walk;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic last;
  } sts_t;

  // ring index increment with wrap
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/overwriting_entry_ring_with_offset_find.sv @@
// top level of the overwriting entry ring with find by character offset
//
// A command beat is taken when start is high and busy is low. An add reads
// the oldest entry from the entry ram while the command is taken, and the
// new entry is written in the next cycle. A find first primes the ram read,
// then walks the ring slots one by one from the oldest entry, ending at the
// first entry whose span covers the offset or after all DEPTH slots; the
// walk is paced by the single ram read port. Every command gives exactly one
// result, shown on the out_ ports for one cycle with out_valid high, in the
// cycle after the last busy cycle. The receiver cannot stall, so a result
// not taken in that cycle is lost. Reset clears the ring at once through
// per-slot valid flops; no clearing pass is needed.
module overwriting_entry_ring_with_offset_find (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [oerf_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [oerf_pkg::SIZE_W-1:0]   in_entry_size,
  input  logic [oerf_pkg::OFS_W-1:0]    in_char_offset,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [oerf_pkg::HANDLE_W-1:0] out_hit_handle,
  output logic [oerf_pkg::SIZE_W-1:0]   out_hit_size,
  output logic [oerf_pkg::SIZE_W-1:0]   out_byte_within,
  output logic                          out_replaced_valid,
  output logic [oerf_pkg::HANDLE_W-1:0] out_replaced_handle
);
  import oerf_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  oerf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  // storage and walk datapath
  oerf_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_entry_handle     (in_entry_handle),
    .in_entry_size       (in_entry_size),
    .in_char_offset      (in_char_offset),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_hit_handle      (out_hit_handle),
    .out_hit_size        (out_hit_size),
    .out_byte_within     (out_byte_within),
    .out_replaced_valid  (out_replaced_valid),
    .out_replaced_handle (out_replaced_handle)
  );

endmodule

@@ rtl/oerf_ram.sv @@
// generic simple dual port ram with registered read
module oerf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/oerf_ctrl.sv @@
// command sequencer of the overwriting entry ring
module oerf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_cmd,
  input  oerf_pkg::sts_t sts,
  output oerf_pkg::ctl_t ctl,
  output logic          busy
);
  import oerf_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_cmd == CMD_FIND) ? ST_FIND : ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = ST_IDLE;
      end
      ST_FIND: begin
        if (sts.hit || sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    ctl       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_ADD: begin
        ctl.add_wr = 1'b1;
      end
      ST_FIND: begin
        ctl.find_step = 1'b1;
        ctl.sel_walk  = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/oerf_dp.sv @@
// ring storage, index registers, size walk and result register
module oerf_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  oerf_pkg::ctl_t                  ctl,
  output oerf_pkg::sts_t                  sts,
  input  logic [oerf_pkg::HANDLE_W-1:0]   in_entry_handle,
  input  logic [oerf_pkg::SIZE_W-1:0]     in_entry_size,
  input  logic [oerf_pkg::OFS_W-1:0]      in_char_offset,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [oerf_pkg::HANDLE_W-1:0]   out_hit_handle,
  output logic [oerf_pkg::SIZE_W-1:0]     out_hit_size,
  output logic [oerf_pkg::SIZE_W-1:0]     out_byte_within,
  output logic                            out_replaced_valid,
  output logic [oerf_pkg::HANDLE_W-1:0]   out_replaced_handle
);
  import oerf_pkg::*;

  // ring state
  logic [IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                full_r, full_nxt;
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  // latched command beat
  logic [HANDLE_W-1:0] handle_r;
  logic [SIZE_W-1:0]   size_r;
  logic [OFS_W-1:0]    offset_r;
  // walk state
  logic [IDX_W-1:0]    walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]    eval_idx_r, eval_idx_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  // result register
  logic                out_valid_r;
  logic                found_r;
  logic [HANDLE_W-1:0] hit_handle_r;
  logic [SIZE_W-1:0]   hit_size_r;
  logic [SIZE_W-1:0]   byte_within_r;
  logic                repl_valid_r;
  logic [HANDLE_W-1:0] repl_handle_r;

  // ram ports
  logic [IDX_W-1:0]    raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [HANDLE_W-1:0] rd_handle;
  logic [SIZE_W-1:0]   rd_size;

  // walk compare
  logic [CMP_W-1:0]    acc_ext;
  logic [CMP_W-1:0]    sum_ext;
  logic [CMP_W-1:0]    ofs_ext;
  logic [CMP_W-1:0]    diff_ext;
  logic                ev_valid;
  logic                hit;
  logic                last;
  logic                find_done;

  // entry store, handle and size side by side
  assign raddr = ctl.sel_walk ? walk_idx_r : rd_idx_r;

  oerf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.add_wr),
    .waddr (wr_idx_r),
    .wdata ({handle_r, size_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_handle = rdata[ENTRY_W-1:SIZE_W];
  assign rd_size   = rdata[SIZE_W-1:0];

  // span check of the entry read back this cycle
  assign acc_ext   = CMP_W'(acc_r);
  assign sum_ext   = acc_ext + CMP_W'(rd_size);
  assign ofs_ext   = CMP_W'(offset_r);
  assign diff_ext  = ofs_ext - acc_ext;
  assign ev_valid  = valid_r[eval_idx_r];
  assign hit       = ev_valid && (sum_ext > ofs_ext);
  assign last      = (cnt_r == IDX_W'(DEPTH - 1));
  assign find_done = ctl.find_step && (hit || last);

  assign sts.hit  = hit;
  assign sts.last = last;

  // ring index and valid update
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    full_nxt   = full_r;
    valid_nxt  = valid_r;
    if (ctl.add_wr) begin
      wr_idx_nxt = ring_next(wr_idx_r);
      if (full_r) begin
        rd_idx_nxt = ring_next(rd_idx_r);
      end else begin
        valid_nxt[wr_idx_r] = 1'b1;
        full_nxt            = (ring_next(wr_idx_r) == rd_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      full_r   <= 1'b0;
      valid_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      full_r   <= full_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      handle_r <= in_entry_handle;
      size_r   <= in_entry_size;
      offset_r <= in_char_offset;
    end
  end

  // walk pointers and running total
  always_comb begin
    walk_idx_nxt = walk_idx_r;
    eval_idx_nxt = eval_idx_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    if (ctl.load) begin
      eval_idx_nxt = rd_idx_r;
      walk_idx_nxt = ring_next(rd_idx_r);
      cnt_nxt      = '0;
      acc_nxt      = '0;
    end else if (ctl.find_step) begin
      eval_idx_nxt = walk_idx_r;
      walk_idx_nxt = ring_next(walk_idx_r);
      cnt_nxt      = cnt_r + 1'b1;
      if (ev_valid) begin
        acc_nxt = ACC_W'(sum_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    eval_idx_r <= eval_idx_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.add_wr || find_done;
    end
  end

  // result payload, unused fields forced to zero
  always_ff @(posedge clk) begin
    if (ctl.add_wr) begin
      found_r       <= 1'b0;
      hit_handle_r  <= '0;
      hit_size_r    <= '0;
      byte_within_r <= '0;
      repl_valid_r  <= full_r;
      repl_handle_r <= full_r ? rd_handle : '0;
    end else if (find_done) begin
      found_r       <= hit;
      hit_handle_r  <= hit ? rd_handle : '0;
      hit_size_r    <= hit ? rd_size : '0;
      byte_within_r <= hit ? diff_ext[SIZE_W-1:0] : '0;
      repl_valid_r  <= 1'b0;
      repl_handle_r <= '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = found_r;
  assign out_hit_handle      = hit_handle_r;
  assign out_hit_size        = hit_size_r;
  assign out_byte_within     = byte_within_r;
  assign out_replaced_valid  = repl_valid_r;
  assign out_replaced_handle = repl_handle_r;

endmodule

@@ rtl/oerf_chk.sv @@
// port level checks of the overwriting entry ring, bound to the top level
module oerf_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_cmd,
  input logic [oerf_pkg::HANDLE_W-1:0] in_entry_handle,
  input logic [oerf_pkg::SIZE_W-1:0]   in_entry_size,
  input logic [oerf_pkg::OFS_W-1:0]    in_char_offset,
  input logic                          out_valid,
  input logic                          out_found,
  input logic [oerf_pkg::HANDLE_W-1:0] out_hit_handle,
  input logic [oerf_pkg::SIZE_W-1:0]   out_hit_size,
  input logic [oerf_pkg::SIZE_W-1:0]   out_byte_within,
  input logic                          out_replaced_valid,
  input logic [oerf_pkg::HANDLE_W-1:0] out_replaced_handle
);

  // a taken command always makes the block go busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command taken without going busy");

  // a result beat is never followed directly by another
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  // a result only appears once the command has finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // add and find fields never both claim the beat
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_replaced_valid))
    else $error("result marks both found and replaced");

  // a miss reports zero hit fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_hit_handle == '0 && out_hit_size == '0 && out_byte_within == '0)
    else $error("miss result with nonzero hit fields");

endmodule

bind overwriting_entry_ring_with_offset_find oerf_chk u_oerf_chk (.*);
